// ===== rtl/dual_sum_check_frame_builder_macros.svh =====
// Assertion helpers for the checker file.
`ifndef DUAL_SUM_CHECK_FRAME_BUILDER_MACROS_SVH
`define DUAL_SUM_CHECK_FRAME_BUILDER_MACROS_SVH

// Clocked property, switched off while reset is high.
`define DSCFB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked property that also holds across reset.
`define DSCFB_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/dscfb_pkg.sv =====
package dscfb_pkg;

   localparam int NUM_VALUES = 5;
   localparam int IDX_W      = 4;

   localparam logic [7:0] HDR_BYTE = 8'hAA;
   localparam logic [7:0] TLM_DEST = 8'hFF;
   localparam logic [7:0] TLM_FUNC = 8'hF1;
   localparam logic [7:0] TLM_LEN  = 8'd8;
   localparam logic [7:0] SRV_DEST = 8'h30;
   localparam logic [7:0] SRV_LEN  = 8'd10;

   // byte positions inside a frame
   localparam logic [IDX_W-1:0] POS_HDR  = 4'd0;
   localparam logic [IDX_W-1:0] POS_DEST = 4'd1;
   localparam logic [IDX_W-1:0] POS_FUNC = 4'd2;
   localparam logic [IDX_W-1:0] POS_LEN  = 4'd3;
   localparam logic [IDX_W-1:0] POS_DATA = 4'd4;
   localparam logic [IDX_W-1:0] TLM_SUM_POS = 4'd12;
   localparam logic [IDX_W-1:0] TLM_ACC_POS = 4'd13;
   localparam logic [IDX_W-1:0] SRV_SUM_POS = 4'd14;
   localparam logic [IDX_W-1:0] SRV_ACC_POS = 4'd15;

   typedef struct packed {
      logic                        servo;
      logic [7:0]                  func;
      logic [NUM_VALUES-1:0][15:0] values;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/dscfb_front.sv =====
module dscfb_front (
   input  logic                 push,
   input  logic                 req_type,
   input  logic [7:0]           req_func_code,
   input  logic [15:0]          req_value_0,
   input  logic [15:0]          req_value_1,
   input  logic [15:0]          req_value_2,
   input  logic [15:0]          req_value_3,
   input  logic [15:0]          req_value_4,
   input  dscfb_pkg::q_status_type q_status,
   output logic                 full,
   output logic                 q_wr,
   output dscfb_pkg::job_type   q_wdata
);
   import dscfb_pkg::*;

   assign full = q_status.full;
   assign q_wr = push && !q_status.full;

   // telemetry frames carry a fixed function code and only four values
   always_comb begin
      q_wdata.servo     = req_type;
      q_wdata.func      = req_type ? req_func_code : TLM_FUNC;
      q_wdata.values[0] = req_value_0;
      q_wdata.values[1] = req_value_1;
      q_wdata.values[2] = req_value_2;
      q_wdata.values[3] = req_value_3;
      q_wdata.values[4] = req_type ? req_value_4 : 16'h0000;
   end

endmodule

// ===== rtl/dscfb_queue.sv =====
module dscfb_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr,
   input  dscfb_pkg::job_type     wdata,
   input  logic                   rd,
   output dscfb_pkg::job_type     rdata,
   output dscfb_pkg::q_status_type status
);
   import dscfb_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_wr = wr && !status.full;
   assign do_rd = rd && !status.empty;
   assign rdata = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/dscfb_back.sv =====
module dscfb_back (
   input  logic                   clock,
   input  logic                   reset,
   input  dscfb_pkg::job_type     head,
   input  dscfb_pkg::q_status_type q_status,
   output logic                   q_rd,
   input  logic                   pop,
   output logic                   empty,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_byte
);
   import dscfb_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       sum_ff, sum_in;
   logic [7:0]       acc_ff, acc_in;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic             out_last_ff;

   logic             advance;
   logic             is_sum, is_acc;
   logic [IDX_W-1:0] data_off;
   logic [15:0]      word;
   logic [7:0]       data_byte;
   logic [7:0]       next_byte;

   assign advance  = !q_status.empty && (!out_valid_ff || pop);
   assign is_sum   = idx_ff == (head.servo ? SRV_SUM_POS : TLM_SUM_POS);
   assign is_acc   = idx_ff == (head.servo ? SRV_ACC_POS : TLM_ACC_POS);
   assign data_off = idx_ff - POS_DATA;
   assign q_rd     = advance && is_acc;

   always_comb begin
      unique case (data_off[IDX_W-1:1])
         3'd0:    word = head.values[0];
         3'd1:    word = head.values[1];
         3'd2:    word = head.values[2];
         3'd3:    word = head.values[3];
         3'd4:    word = head.values[4];
         default: word = 16'h0000;
      endcase
   end

   always_comb begin
      unique case (idx_ff)
         POS_HDR:  data_byte = HDR_BYTE;
         POS_DEST: data_byte = head.servo ? SRV_DEST : TLM_DEST;
         POS_FUNC: data_byte = head.func;
         POS_LEN:  data_byte = head.servo ? SRV_LEN : TLM_LEN;
         default:  data_byte = data_off[0] ? word[15:8] : word[7:0];
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      acc_in       = acc_ff;
      next_byte    = data_byte;
      out_valid_in = out_valid_ff && !pop;
      if (advance) begin
         out_valid_in = 1'b1;
         priority if (is_acc) begin
            next_byte = acc_ff;
            idx_in    = '0;
            sum_in    = '0;
            acc_in    = '0;
         end else if (is_sum) begin
            next_byte = sum_ff;
            idx_in    = idx_ff + 1'b1;
         end else begin
            idx_in = idx_ff + 1'b1;
            sum_in = sum_ff + data_byte;
            acc_in = acc_ff + sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         sum_ff       <= '0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         sum_ff       <= sum_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_byte_ff <= next_byte;
         out_last_ff <= is_acc;
      end
   end

   assign empty          = !out_valid_ff;
   assign rsp_frame_byte = out_byte_ff;
   assign rsp_last_byte  = out_last_ff;

endmodule

// ===== rtl/dual_sum_check_frame_builder.sv =====
// Dual-check serial frame builder. Every request transaction becomes one frame that
// leaves on the rsp_ side one byte per transaction: header 0xAA, destination, function,
// length, the 16-bit values low byte first, then the sum check (8-bit sum of all bytes
// before it) and the add check (8-bit sum of the running sums); rsp_last_byte marks
// the add check. req_type 0 gives a 14-byte telemetry frame (dest 0xFF, func 0xF1,
// four values), req_type 1 a 16-byte servo frame (dest 0x30, func from
// req_func_code, five values). The byte serializer in the back end emits one byte
// per cycle while each byte is popped as it appears; a byte left unpopped stalls it.
// Requests land in a QUEUE_DEPTH-entry job queue, so full stays low while the
// serializer is busy until the queue fills. A taken request is first written into
// the job queue and its first byte is then registered onto the rsp_ ports, where it
// can be popped once empty is low; a stalled byte holds until popped.
module dual_sum_check_frame_builder #(
   parameter int QUEUE_DEPTH = 2   // 2 or more
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_type,
   input  logic [7:0]  req_func_code,
   input  logic [15:0] req_value_0,
   input  logic [15:0] req_value_1,
   input  logic [15:0] req_value_2,
   input  logic [15:0] req_value_3,
   input  logic [15:0] req_value_4,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_last_byte
);
   import dscfb_pkg::*;

   job_type      q_wdata;
   job_type      q_head;
   q_status_type q_status;
   logic         q_wr;
   logic         q_rd;

   // front: takes requests and turns them into frame jobs
   dscfb_front u_front (
      .push          (push),
      .req_type      (req_type),
      .req_func_code (req_func_code),
      .req_value_0   (req_value_0),
      .req_value_1   (req_value_1),
      .req_value_2   (req_value_2),
      .req_value_3   (req_value_3),
      .req_value_4   (req_value_4),
      .q_status      (q_status),
      .full          (full),
      .q_wr          (q_wr),
      .q_wdata       (q_wdata)
   );

   // job queue decouples request intake from the serializer
   dscfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr     (q_wr),
      .wdata  (q_wdata),
      .rd     (q_rd),
      .rdata  (q_head),
      .status (q_status)
   );

   // back: walks the head job byte by byte, keeps both checks,
   // retires the job on the add check byte
   dscfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (q_head),
      .q_status       (q_status),
      .q_rd           (q_rd),
      .pop            (pop),
      .empty          (empty),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

endmodule

// ===== rtl/dscfb_checker.sv =====
`include "dual_sum_check_frame_builder_macros.svh"

module dscfb_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_frame_byte,
   input logic       rsp_last_byte
);
   import dscfb_pkg::*;

   logic [IDX_W-1:0] pos_ff, pos_in;
   logic             taken;

   assign taken = pop && !empty;

   always_comb begin
      pos_in = pos_ff;
      if (taken) begin
         pos_in = rsp_last_byte ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   `DSCFB_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (empty && !full), "reset left state")
   `DSCFB_ASSERT(a_rsp_hold, clock, reset, (!empty && !pop) |=> (!empty && $stable(rsp_frame_byte) && $stable(rsp_last_byte)), "stalled byte changed")
   `DSCFB_ASSERT(a_frame_header, clock, reset, (!empty && pos_ff == POS_HDR) |-> (rsp_frame_byte == HDR_BYTE), "frame does not open with header")
   `DSCFB_ASSERT(a_last_position, clock, reset, (!empty && rsp_last_byte) |-> (pos_ff == TLM_ACC_POS || pos_ff == SRV_ACC_POS), "last byte at bad position")

endmodule

bind dual_sum_check_frame_builder dscfb_checker u_checker (.*);
